FILE: design/round_robin_process_scheduler_assert.svh
// Assertion helpers for the process scheduler
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define RRPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RRPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/rrps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrps_pkg;

   // slot table geometry
   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = 3;
   localparam int DATA_W    = 16;

   localparam logic [DATA_W-1:0] STACK_INIT = 16'hff00;
   // segment of slot s is (s + SEG_BASE) << 12
   localparam logic [SLOT_W:0]   SEG_BASE   = 4'd2;

   // request kinds
   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_CREATE  = 3'd1;
   localparam logic [2:0] REQ_KILL    = 3'd2;
   localparam logic [2:0] REQ_TERM    = 3'd3;
   localparam logic [2:0] REQ_KILLALL = 3'd4;

   typedef logic [NUM_SLOTS-1:0] slot_mask_type;

endpackage

`default_nettype wire

FILE: design/round_robin_process_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
//  channel | dir | handshake                   | payload
//  req     | in  | req_tvalid / req_tready      | req_tuser kind, req_tdata request fields
//  rsp     | out | rsp_tvalid / rsp_tready      | rsp_tuser flags, rsp_tdata result fields
//
//  A request is taken in the idle state, which issues the saved-stack
//  memory read; the read state then loads the output register from its data.
//  The result register frees the request side: a new request is taken
//  while an earlier result still waits, and a stalled result only holds
//  the read state of the next request. Reset is synchronous, active high;
//  the stack memory needs no clearing pass, per-slot valid bits stand in.

`include "round_robin_process_scheduler_assert.svh"

module round_robin_process_scheduler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // segment_in[15:0], stack_in[31:16], kill_slot[34:32]
   input  wire logic [2:0]  req_tuser,  // req_type[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // segment_out[15:0], stack_out[31:16], slot_out[34:32]
   output logic [1:0]       rsp_tuser   // full_res[0], switched[1]
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   localparam int SW = rrps_pkg::SLOT_W;
   localparam int DW = rrps_pkg::DATA_W;

   logic                        state_ff, state_in;
   rrps_pkg::slot_mask_type     slot_active_ff, slot_active_in;
   rrps_pkg::slot_mask_type     stack_valid_ff, stack_valid_in;
   logic [SW-1:0]               cur_ff, cur_in;

   // saved stack memory, one write and one read port
   logic [DW-1:0]               stack_mem [rrps_pkg::NUM_SLOTS];
   logic [DW-1:0]               mem_q_ff;
   logic                        mem_we;

   // request fields
   logic                        req_fire;
   logic [2:0]                  kind;
   logic [DW-1:0]               seg_in, sp_in;
   logic [SW-1:0]               kill_in;

   // search results
   logic                        owned;
   logic [SW-1:0]               pick;
   logic                        pick_found;
   logic [SW-1:0]               free_slot;
   logic                        free_found;

   // result captured at accept
   logic [DW-1:0]               pend_seg_ff, pend_seg_in;
   logic [DW-1:0]               pend_stack_ff, pend_stack_in;
   logic [SW-1:0]               pend_slot_ff, pend_slot_in;
   logic                        pend_full_ff, pend_full_in;
   logic                        pend_sw_ff, pend_sw_in;
   logic                        pend_mem_ff, pend_mem_in;

   // output register
   logic                        rsp_valid_ff;
   logic [DW-1:0]               rsp_seg_ff, rsp_stack_ff;
   logic [SW-1:0]               rsp_slot_ff;
   logic                        rsp_full_ff, rsp_sw_ff;
   logic                        load_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign kind       = req_tuser;
   assign seg_in     = req_tdata[15:0];
   assign sp_in      = req_tdata[31:16];
   assign kill_in    = req_tdata[34:32];

   // interrupted segment belongs to the current slot
   assign owned = (seg_in[15:12] == ({1'b0, cur_ff} + rrps_pkg::SEG_BASE));

   // round-robin search: after current, wrapping to current itself
   always_comb begin
      logic [SW:0] idx_w;
      pick       = cur_ff;
      pick_found = 1'b0;
      idx_w      = '0;
      for (int k = rrps_pkg::NUM_SLOTS; k >= 1; k--) begin
         idx_w = {1'b0, cur_ff} + (SW+1)'(k);
         if (idx_w >= (SW+1)'(rrps_pkg::NUM_SLOTS)) begin
            idx_w = idx_w - (SW+1)'(rrps_pkg::NUM_SLOTS);
         end
         if (slot_active_ff[idx_w[SW-1:0]]) begin
            pick       = idx_w[SW-1:0];
            pick_found = 1'b1;
         end
      end
   end

   // lowest free slot
   always_comb begin
      free_slot  = '0;
      free_found = 1'b0;
      for (int i = rrps_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (!slot_active_ff[i]) begin
            free_slot  = SW'(i);
            free_found = 1'b1;
         end
      end
   end

   // table update and result capture at accept
   always_comb begin
      slot_active_in = slot_active_ff;
      stack_valid_in = stack_valid_ff;
      cur_in         = cur_ff;
      mem_we         = 1'b0;
      pend_seg_in    = pend_seg_ff;
      pend_stack_in  = pend_stack_ff;
      pend_slot_in   = pend_slot_ff;
      pend_full_in   = pend_full_ff;
      pend_sw_in     = pend_sw_ff;
      pend_mem_in    = pend_mem_ff;
      if (req_fire) begin
         pend_seg_in   = '0;
         pend_stack_in = '0;
         pend_slot_in  = '0;
         pend_full_in  = 1'b0;
         pend_sw_in    = 1'b0;
         pend_mem_in   = 1'b0;
         case (kind)
            rrps_pkg::REQ_TICK: begin
               if (owned) begin
                  mem_we                 = 1'b1;
                  stack_valid_in[cur_ff] = 1'b1;
               end
               if (pick_found) begin
                  cur_in       = pick;
                  pend_seg_in  = {({1'b0, pick} + rrps_pkg::SEG_BASE), 12'h000};
                  pend_slot_in = pick;
                  pend_sw_in   = 1'b1;
                  // forward the stack just saved, else memory or reset value
                  if (owned && (pick == cur_ff)) begin
                     pend_stack_in = sp_in;
                  end else if (stack_valid_ff[pick]) begin
                     pend_mem_in = 1'b1;
                  end else begin
                     pend_stack_in = rrps_pkg::STACK_INIT;
                  end
               end else begin
                  pend_seg_in   = seg_in;
                  pend_stack_in = sp_in;
                  pend_slot_in  = cur_ff;
               end
            end
            rrps_pkg::REQ_CREATE: begin
               if (free_found) begin
                  slot_active_in[free_slot] = 1'b1;
                  stack_valid_in[free_slot] = 1'b0;
                  pend_seg_in   = {({1'b0, free_slot} + rrps_pkg::SEG_BASE), 12'h000};
                  pend_stack_in = rrps_pkg::STACK_INIT;
                  pend_slot_in  = free_slot;
               end else begin
                  pend_full_in = 1'b1;
               end
            end
            rrps_pkg::REQ_KILL: begin
               if ({1'b0, kill_in} < (SW+1)'(rrps_pkg::NUM_SLOTS)) begin
                  slot_active_in[kill_in] = 1'b0;
               end
               pend_slot_in = kill_in;
            end
            rrps_pkg::REQ_TERM: begin
               slot_active_in[cur_ff] = 1'b0;
               stack_valid_in[cur_ff] = 1'b0;
               pend_slot_in           = cur_ff;
            end
            rrps_pkg::REQ_KILLALL: begin
               slot_active_in         = '0;
               stack_valid_in[cur_ff] = 1'b0;
               pend_slot_in           = cur_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer
   assign load_rsp = (state_ff == ST_READ) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         slot_active_ff <= '0;
         stack_valid_ff <= '0;
         cur_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         slot_active_ff <= slot_active_in;
         stack_valid_ff <= stack_valid_in;
         cur_ff         <= cur_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // stack memory: write the interrupted stack, read the picked slot
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[cur_ff] <= sp_in;
      end
      if (req_fire) begin
         mem_q_ff <= stack_mem[pick];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_seg_ff   <= pend_seg_in;
      pend_stack_ff <= pend_stack_in;
      pend_slot_ff  <= pend_slot_in;
      pend_full_ff  <= pend_full_in;
      pend_sw_ff    <= pend_sw_in;
      pend_mem_ff   <= pend_mem_in;
      if (load_rsp) begin
         rsp_seg_ff   <= pend_seg_ff;
         rsp_stack_ff <= pend_mem_ff ? mem_q_ff : pend_stack_ff;
         rsp_slot_ff  <= pend_slot_ff;
         rsp_full_ff  <= pend_full_ff;
         rsp_sw_ff    <= pend_sw_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_slot_ff, rsp_stack_ff, rsp_seg_ff};
   assign rsp_tuser  = {rsp_sw_ff, rsp_full_ff};

   // checks
   `RRPS_ASSERT_NXT(a_accept_reads, clock, reset, req_fire, state_ff == ST_READ,
      "accepted request did not enter the read cycle")
   `RRPS_ASSERT_NXT(a_tick_lands_active, clock, reset,
      req_fire && (kind == rrps_pkg::REQ_TICK) && (|slot_active_ff),
      slot_active_ff[cur_ff], "tick switched to an inactive slot")
   `RRPS_ASSERT_NXT(a_create_adds_one, clock, reset,
      req_fire && (kind == rrps_pkg::REQ_CREATE) && !(&slot_active_ff),
      $countones(slot_active_ff) == $past($countones(slot_active_ff)) + 1,
      "create did not activate exactly one slot")

endmodule

`default_nettype wire

FILE: bench/tb_round_robin_process_scheduler.sv
`timescale 1ns / 1ps

module tb_round_robin_process_scheduler;

   // request codes the block treats as unknown
   localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
   localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;

   localparam int RANDOM_REQS  = 1080;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [2:0]                  kind;
      logic [rrps_pkg::DATA_W-1:0] segment;
      logic [rrps_pkg::DATA_W-1:0] stack;
      logic [rrps_pkg::SLOT_W-1:0] victim;
   } sched_req_type;

   typedef struct packed {
      logic [rrps_pkg::DATA_W-1:0] segment;
      logic [rrps_pkg::DATA_W-1:0] stack;
      logic [rrps_pkg::SLOT_W-1:0] slot;
      logic                        full;
      logic                        switched;
   } sched_rsp_type;

   // per-request tag: use the hand-typed result or the predicted one
   typedef struct packed {
      logic          fixed;
      sched_rsp_type want;
   } req_tag_type;

   typedef struct packed {
      sched_req_type req;
      req_tag_type   tag;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // segment_in[15:0], stack_in[31:16], kill_slot[34:32]
   logic [2:0]  req_tuser;   // req_type[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // segment_out[15:0], stack_out[31:16], slot_out[34:32]
   logic [1:0]  rsp_tuser;   // full_res[0], switched[1]

   // shadow of the slot table
   rrps_pkg::slot_mask_type     active_mask = '0;
   logic [rrps_pkg::DATA_W-1:0] stack_tab [rrps_pkg::NUM_SLOTS];
   logic [rrps_pkg::SLOT_W-1:0] cur_slot = '0;

   sched_rsp_type outcome_q [$];
   req_tag_type   tag_q [$];
   table_row_type directed_rows [$];

   int err_count    = 0;
   int stall_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int n_tick = 0, n_switch = 0, n_create = 0, n_full = 0;
   int n_kill = 0, n_term = 0, n_killall = 0, n_rsvd = 0, n_rsp = 0;

   round_robin_process_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   task automatic report_error(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want) begin
         report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
      end
   endtask

   // one scheduler step on the shadow table
   function automatic sched_rsp_type schedule_step(sched_req_type r);
      sched_rsp_type o;
      logic [3:0]    hi;
      int            idx;
      bit            found;
      o = '0;
      found = 1'b0;
      case (r.kind)
         rrps_pkg::REQ_TICK: begin
            hi = r.segment[15:12];
            // save the stack only when the segment belongs to the current slot
            if (hi >= rrps_pkg::SEG_BASE &&
                (hi - rrps_pkg::SEG_BASE) == {1'b0, cur_slot}) begin
               stack_tab[cur_slot] = r.stack;
            end
            for (int k = 1; k <= rrps_pkg::NUM_SLOTS; k++) begin
               idx = (int'(cur_slot) + k) % rrps_pkg::NUM_SLOTS;
               if (!found && active_mask[idx]) begin
                  found = 1'b1;
                  cur_slot = rrps_pkg::SLOT_W'(idx);
                  o.segment = {rrps_pkg::SEG_BASE + 4'(idx), 12'h000};
                  o.stack = stack_tab[idx];
                  o.slot = rrps_pkg::SLOT_W'(idx);
                  o.switched = 1'b1;
               end
            end
            // nothing runnable: echo the interrupted context
            if (!found) begin
               o.segment = r.segment;
               o.stack = r.stack;
               o.slot = cur_slot;
            end
         end
         rrps_pkg::REQ_CREATE: begin
            for (int s = 0; s < rrps_pkg::NUM_SLOTS; s++) begin
               if (!found && !active_mask[s]) begin
                  found = 1'b1;
                  active_mask[s] = 1'b1;
                  stack_tab[s] = rrps_pkg::STACK_INIT;
                  o.segment = {rrps_pkg::SEG_BASE + 4'(s), 12'h000};
                  o.stack = rrps_pkg::STACK_INIT;
                  o.slot = rrps_pkg::SLOT_W'(s);
               end
            end
            if (!found) begin
               o.full = 1'b1;
            end
         end
         rrps_pkg::REQ_KILL: begin
            if (int'(r.victim) < rrps_pkg::NUM_SLOTS) begin
               active_mask[r.victim] = 1'b0;
            end
            o.slot = r.victim;
         end
         rrps_pkg::REQ_TERM: begin
            active_mask[cur_slot] = 1'b0;
            stack_tab[cur_slot] = rrps_pkg::STACK_INIT;
            o.slot = cur_slot;
         end
         rrps_pkg::REQ_KILLALL: begin
            active_mask = '0;
            stack_tab[cur_slot] = rrps_pkg::STACK_INIT;
            o.slot = cur_slot;
         end
         default: begin
            o = '0;
         end
      endcase
      return o;
   endfunction

   // present one request; returns right after the accepting edge
   task automatic send_req(sched_req_type r, bit fixed, sched_rsp_type want);
      req_tag_type t;
      t.fixed = fixed;
      t.want = want;
      tag_q.push_back(t);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.kind;
      req_tdata <= {5'b0, r.victim, r.stack, r.segment};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic add_row(logic [2:0] kind, logic [15:0] seg, logic [15:0] stk,
                          logic [2:0] victim, bit fixed, logic [15:0] wseg,
                          logic [15:0] wstk, logic [2:0] wslot, logic wfull,
                          logic wsw);
      table_row_type row;
      row.req = '{kind, seg, stk, victim};
      row.tag.fixed = fixed;
      row.tag.want = '{wseg, wstk, wslot, wfull, wsw};
      directed_rows.push_back(row);
   endtask

   // random request shaped around the current table contents
   function automatic sched_req_type pick_random_req();
      sched_req_type r;
      int roll;
      int seg_roll;
      r.segment = 16'($urandom);
      r.stack = 16'($urandom);
      r.victim = rrps_pkg::SLOT_W'($urandom_range(rrps_pkg::NUM_SLOTS - 1));
      roll = $urandom_range(99);
      seg_roll = $urandom_range(99);
      if (roll < 45) begin
         r.kind = rrps_pkg::REQ_TICK;
         if (seg_roll < 50) begin
            r.segment = {rrps_pkg::SEG_BASE + 4'(cur_slot), 12'($urandom)};
         end else if (seg_roll < 70) begin
            r.segment = {rrps_pkg::SEG_BASE + 4'($urandom_range(rrps_pkg::NUM_SLOTS - 1)),
                         12'($urandom)};
         end
      end else if (roll < 67) begin
         r.kind = rrps_pkg::REQ_CREATE;
      end else if (roll < 82) begin
         r.kind = rrps_pkg::REQ_KILL;
      end else if (roll < 90) begin
         r.kind = rrps_pkg::REQ_TERM;
      end else if (roll < 94) begin
         r.kind = rrps_pkg::REQ_KILLALL;
      end else begin
         r.kind = 3'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
      end
      return r;
   endfunction

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // check results, predict on accepted requests
   always @(posedge clock) begin : monitor
      sched_req_type seen;
      sched_rsp_type want;
      sched_rsp_type pred;
      req_tag_type   tag;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            if (outcome_q.size() == 0) begin
               report_error("result transfer with nothing expected");
            end else begin
               want = outcome_q.pop_front();
               check_field("segment_out", rsp_tdata[15:0], want.segment);
               check_field("stack_out", rsp_tdata[31:16], want.stack);
               check_field("slot_out", rsp_tdata[34:32], want.slot);
               check_field("full_res", rsp_tuser[0], want.full);
               check_field("switched", rsp_tuser[1], want.switched);
            end
         end
         if (req_tvalid && req_tready) begin
            seen.kind = req_tuser;
            seen.segment = req_tdata[15:0];
            seen.stack = req_tdata[31:16];
            seen.victim = req_tdata[34:32];
            pred = schedule_step(seen);
            tag = tag_q.pop_front();
            outcome_q.push_back(tag.fixed ? tag.want : pred);
            case (seen.kind)
               rrps_pkg::REQ_TICK: begin
                  n_tick++;
                  if (pred.switched) n_switch++;
               end
               rrps_pkg::REQ_CREATE: begin
                  n_create++;
                  if (pred.full) n_full++;
               end
               rrps_pkg::REQ_KILL:    n_kill++;
               rrps_pkg::REQ_TERM:    n_term++;
               rrps_pkg::REQ_KILLALL: n_killall++;
               default:               n_rsvd++;
            endcase
         end
      end
   end

   // no transfer for too long
   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_round_robin_process_scheduler: done, errors");
      $finish;
   end

   initial begin : stimulus
      sched_req_type r;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = rrps_pkg::REQ_TICK;
      rsp_tready = 1'b0;
      for (int s = 0; s < rrps_pkg::NUM_SLOTS; s++) begin
         stack_tab[s] = rrps_pkg::STACK_INIT;
      end

      // directed rows: kind, seg, stack, victim, fixed, expected fields
      add_row(rrps_pkg::REQ_TICK, 16'h0000, 16'h0000, 3'd0, 1,
              16'h0000, 16'h0000, 3'd0, 0, 0);
      add_row(rrps_pkg::REQ_TICK, 16'hffff, 16'hffff, 3'd7, 1,
              16'hffff, 16'hffff, 3'd0, 0, 0);
      add_row(rrps_pkg::REQ_TERM, 16'hffff, 16'hffff, 3'd7, 1,
              16'h0000, 16'h0000, 3'd0, 0, 0);
      add_row(rrps_pkg::REQ_KILLALL, 16'hffff, 16'hffff, 3'd7, 1,
              16'h0000, 16'h0000, 3'd0, 0, 0);
      add_row(REQ_RSVD_FIRST, 16'hffff, 16'hffff, 3'd7, 1, 16'h0000, 16'h0000, 3'd0, 0, 0);
      add_row(REQ_RSVD_LAST, 16'hffff, 16'hffff, 3'd7, 1, 16'h0000, 16'h0000, 3'd0, 0, 0);
      // fill every slot, then one more create reports full
      for (int s = 0; s < rrps_pkg::NUM_SLOTS; s++) begin
         add_row(rrps_pkg::REQ_CREATE, 16'h0000, 16'h0000, 3'd0, 1,
                 {rrps_pkg::SEG_BASE + 4'(s), 12'h000}, rrps_pkg::STACK_INIT, 3'(s), 0, 0);
      end
      add_row(rrps_pkg::REQ_CREATE, 16'hffff, 16'hffff, 3'd7, 1,
              16'h0000, 16'h0000, 3'd0, 1, 0);
      // owned segment saves the stack, then the next slot is picked
      add_row(rrps_pkg::REQ_TICK, 16'h2000, 16'h1234, 3'd0, 0, '0, '0, '0, 0, 0);
      add_row(rrps_pkg::REQ_TICK, 16'h3000, 16'habcd, 3'd0, 0, '0, '0, '0, 0, 0);
      add_row(rrps_pkg::REQ_KILL, 16'h0000, 16'h0000, 3'd7, 1,
              16'h0000, 16'h0000, 3'd7, 0, 0);
      add_row(rrps_pkg::REQ_KILL, 16'hffff, 16'hffff, 3'd0, 1,
              16'h0000, 16'h0000, 3'd0, 0, 0);
      // segments below the slot area and above it are never saved
      add_row(rrps_pkg::REQ_TICK, 16'h1fff, 16'h5555, 3'd0, 0, '0, '0, '0, 0, 0);
      add_row(rrps_pkg::REQ_TICK, 16'hf000, 16'h0001, 3'd0, 0, '0, '0, '0, 0, 0);
      add_row(rrps_pkg::REQ_TERM, 16'h0000, 16'h0000, 3'd0, 0, '0, '0, '0, 0, 0);
      add_row(rrps_pkg::REQ_CREATE, 16'h0000, 16'h0000, 3'd0, 0, '0, '0, '0, 0, 0);
      add_row(rrps_pkg::REQ_TICK, 16'h9000, 16'h4321, 3'd0, 0, '0, '0, '0, 0, 0);
      add_row(rrps_pkg::REQ_KILLALL, 16'h0000, 16'h0000, 3'd0, 0, '0, '0, '0, 0, 0);
      add_row(rrps_pkg::REQ_TICK, 16'h4000, 16'h8888, 3'd0, 0, '0, '0, '0, 0, 0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 38;
      recv_idle_pct = 74;
      foreach (directed_rows[i]) begin
         send_req(directed_rows[i].req, directed_rows[i].tag.fixed,
                  directed_rows[i].tag.want);
      end

      // random traffic in three pressure phases
      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (i == RANDOM_REQS / 3) begin
            send_idle_pct = 74;
            recv_idle_pct = 38;
         end else if (i == 2 * RANDOM_REQS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         r = pick_random_req();
         send_req(r, 1'b0, '0);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d ticks (%0d switches), %0d creates (%0d full), %0d kills,",
               n_tick, n_switch, n_create, n_full, n_kill);
      $display("%0d terminates, %0d kill-alls, %0d unknown kinds; %0d results, %0d errors",
               n_term, n_killall, n_rsvd, n_rsp, err_count);
      if (err_count == 0) begin
         $display("tb_round_robin_process_scheduler: done, clean");
      end else begin
         $display("tb_round_robin_process_scheduler: done, errors");
      end
      $finish;
   end

endmodule
